// File: design/interval_resource_allocator_core_defines.svh
// Assertion macros shared by the interval resource allocator RTL.
`ifndef INTERVAL_RESOURCE_ALLOCATOR_CORE_DEFINES_SVH
`define INTERVAL_RESOURCE_ALLOCATOR_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define IRAC_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("interval allocator assertion failed");
`define IRAC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("interval allocator assertion failed");
`else
`define IRAC_ASSERT_NOW(label, clk, rst_n, pre, post)
`define IRAC_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif

`endif

// File: design/irac_pkg.sv
// Types, microcode encoding and step addresses of the interval resource allocator.
package irac_pkg;

    localparam int TIME_W = 32;
    localparam int TAG_W  = 16;
    localparam int RES_W  = 7;
    localparam int UPC_W  = 4;

    typedef logic [UPC_W-1:0] t_upc;

    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
        logic [TAG_W-1:0]  item_id;
    } t_in;

    typedef struct packed {
        logic [TAG_W-1:0] tag_out;
        logic [RES_W-1:0] resource;
        logic             opened_new;
        logic [RES_W-1:0] resource_count;
        logic             overflow;
        logic             order_error;
    } t_out;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_INS,
        OP_UP_RD,
        OP_UP_STEP,
        OP_RE_SET,
        OP_DN_RD,
        OP_DN_STEP,
        OP_PLACE,
        OP_OVF,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_IN_VALID,
        C_REUSE,
        C_FULL,
        C_AT_ROOT,
        C_MOVED,
        C_NO_CHILD,
        C_OUT_FREE
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_upc  tgt_t;
        t_upc  tgt_f;
    } t_uword;

    typedef struct packed {
        logic reuse;
        logic full;
        logic at_root;
        logic moved;
        logic no_child;
    } t_dpstat;

    localparam t_upc U_WAIT    = 4'd0;
    localparam t_upc U_DECIDE  = 4'd1;
    localparam t_upc U_NEWCHK  = 4'd2;
    localparam t_upc U_INS     = 4'd3;
    localparam t_upc U_UP_RD   = 4'd4;
    localparam t_upc U_UP_STEP = 4'd5;
    localparam t_upc U_DONE    = 4'd6;
    localparam t_upc U_RE_SET  = 4'd7;
    localparam t_upc U_DN_RD   = 4'd8;
    localparam t_upc U_DN_STEP = 4'd9;
    localparam t_upc U_OVF     = 4'd10;
    localparam t_upc U_PLACE   = 4'd11;

endpackage

// File: design/irac_ucode.sv
// Microcode ROM: one control word per program step.
module irac_ucode
    import irac_pkg::*;
(
    input  t_upc   i_upc,
    output t_uword o_uword
);

    always_comb begin
        unique case (i_upc)
            U_WAIT:    o_uword = '{OP_LOAD,    C_IN_VALID, U_DECIDE,  U_WAIT};
            U_DECIDE:  o_uword = '{OP_NOP,     C_REUSE,    U_RE_SET,  U_NEWCHK};
            U_NEWCHK:  o_uword = '{OP_NOP,     C_FULL,     U_OVF,     U_INS};
            U_INS:     o_uword = '{OP_INS,     C_ALWAYS,   U_UP_RD,   U_UP_RD};
            U_UP_RD:   o_uword = '{OP_UP_RD,   C_AT_ROOT,  U_PLACE,   U_UP_STEP};
            U_UP_STEP: o_uword = '{OP_UP_STEP, C_MOVED,    U_UP_RD,   U_DONE};
            U_DONE:    o_uword = '{OP_EMIT,    C_OUT_FREE, U_WAIT,    U_DONE};
            U_RE_SET:  o_uword = '{OP_RE_SET,  C_ALWAYS,   U_DN_RD,   U_DN_RD};
            U_DN_RD:   o_uword = '{OP_DN_RD,   C_NO_CHILD, U_PLACE,   U_DN_STEP};
            U_DN_STEP: o_uword = '{OP_DN_STEP, C_MOVED,    U_DN_RD,   U_DONE};
            U_OVF:     o_uword = '{OP_OVF,     C_ALWAYS,   U_DONE,    U_DONE};
            U_PLACE:   o_uword = '{OP_PLACE,   C_ALWAYS,   U_DONE,    U_DONE};
            default:   o_uword = '{OP_NOP,     C_ALWAYS,   U_WAIT,    U_WAIT};
        endcase
    end

endmodule

// File: design/irac_seq.sv
// Step counter with conditional jumps over the microcode ROM.
module irac_seq
    import irac_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_free,
    input  t_dpstat i_stat,
    output t_uword  o_uword
);

    t_upc   r_upc;
    t_upc   n_upc;
    t_uword uword;
    logic   take;

    irac_ucode u_rom (
        .i_upc   (r_upc),
        .o_uword (uword)
    );

    always_comb begin
        unique case (uword.cond)
            C_ALWAYS:   take = 1'b1;
            C_IN_VALID: take = i_in_valid;
            C_REUSE:    take = i_stat.reuse;
            C_FULL:     take = i_stat.full;
            C_AT_ROOT:  take = i_stat.at_root;
            C_MOVED:    take = i_stat.moved;
            C_NO_CHILD: take = i_stat.no_child;
            C_OUT_FREE: take = i_out_free;
            default:    take = 1'b1;
        endcase
    end

    always_comb begin
        n_upc = take ? uword.tgt_t : uword.tgt_f;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_WAIT;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_uword = uword;

endmodule

// File: design/irac_dp.sv
// Heap datapath: heap memory, moving entry, counters and result fields.
`include "interval_resource_allocator_core_defines.svh"
module irac_dp
    import irac_pkg::*;
#(
    parameter int MAX_RESOURCES = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_uword  i_uword,
    input  logic    i_in_acc,
    input  t_in     i_in,
    output t_dpstat o_stat,
    output t_out    o_res
);

    localparam int AW = $clog2(MAX_RESOURCES);
    localparam int SW = $clog2(MAX_RESOURCES + 1);
    localparam int EW = TIME_W + SW;

    logic [EW-1:0]     mem [MAX_RESOURCES];
    logic [EW-1:0]     r_rd_a;
    logic [EW-1:0]     r_rd_b;

    logic [SW-1:0]     r_size;
    logic [SW-1:0]     n_size;
    logic [SW-1:0]     r_count;
    logic [SW-1:0]     n_count;
    logic [TIME_W-1:0] r_prev;
    logic [TIME_W-1:0] n_prev;

    logic [TIME_W-1:0] r_start;
    logic [TIME_W-1:0] n_start;
    logic [TIME_W-1:0] r_end;
    logic [TIME_W-1:0] n_end;
    logic [TAG_W-1:0]  r_tag;
    logic [TAG_W-1:0]  n_tag;
    logic              r_order;
    logic              n_order;
    logic              r_opened;
    logic              n_opened;
    logic              r_ovf;
    logic              n_ovf;
    logic [SW-1:0]     r_res;
    logic [SW-1:0]     n_res;
    logic [EW-1:0]     r_cur;
    logic [EW-1:0]     n_cur;
    logic [AW-1:0]     r_idx;
    logic [AW-1:0]     n_idx;

    logic [AW-1:0]     addr_a;
    logic [AW-1:0]     addr_b;
    logic              w_en;
    logic [AW-1:0]     w_addr;
    logic [EW-1:0]     w_data;

    logic [AW-1:0]     parent;
    logic [AW+1:0]     left_w;
    logic [AW+1:0]     right_w;
    logic [AW+1:0]     size_w;
    logic              has_left;
    logic              has_right;
    logic              up_less;
    logic              l_lt;
    logic              r_lt;
    logic              r_lt_l;
    logic              pick_r;
    logic              pick_l;

    assign parent    = (r_idx - AW'(1)) >> 1;
    assign left_w    = {1'b0, r_idx, 1'b1};
    assign right_w   = left_w + (AW+2)'(1);
    assign size_w    = (AW+2)'(r_size);
    assign has_left  = left_w < size_w;
    assign has_right = right_w < size_w;
    assign up_less   = r_cur < r_rd_a;
    assign l_lt      = r_rd_a < r_cur;
    assign r_lt      = r_rd_b < r_cur;
    assign r_lt_l    = r_rd_b < r_rd_a;
    assign pick_r    = has_right && (l_lt ? r_lt_l : r_lt);
    assign pick_l    = l_lt && !pick_r;

    always_comb begin
        addr_a = '0;
        addr_b = '0;
        unique case (i_uword.op)
            OP_UP_RD: begin
                addr_a = parent;
            end
            OP_DN_RD: begin
                addr_a = left_w[AW-1:0];
                addr_b = right_w[AW-1:0];
            end
            default: begin
                addr_a = '0;
            end
        endcase
    end

    always_comb begin
        n_size   = r_size;
        n_count  = r_count;
        n_prev   = r_prev;
        n_start  = r_start;
        n_end    = r_end;
        n_tag    = r_tag;
        n_order  = r_order;
        n_opened = r_opened;
        n_ovf    = r_ovf;
        n_res    = r_res;
        n_cur    = r_cur;
        n_idx    = r_idx;
        w_en     = 1'b0;
        w_addr   = r_idx;
        w_data   = r_cur;
        unique case (i_uword.op)
            OP_LOAD: begin
                if (i_in_acc) begin
                    n_start  = i_in.start_time;
                    n_end    = i_in.end_time;
                    n_tag    = i_in.item_id;
                    n_order  = i_in.start_time < r_prev;
                    n_prev   = i_in.start_time;
                    n_opened = 1'b0;
                    n_ovf    = 1'b0;
                    n_res    = '0;
                end
            end
            OP_INS: begin
                n_count  = r_count + SW'(1);
                n_res    = r_count + SW'(1);
                n_opened = 1'b1;
                n_cur    = {r_end, r_count + SW'(1)};
                n_idx    = r_size[AW-1:0];
                n_size   = r_size + SW'(1);
            end
            OP_UP_STEP: begin
                w_en = 1'b1;
                if (up_less) begin
                    w_data = r_rd_a;
                    n_idx  = parent;
                end
            end
            OP_RE_SET: begin
                n_res = r_rd_a[SW-1:0];
                n_cur = {r_end, r_rd_a[SW-1:0]};
                n_idx = '0;
            end
            OP_DN_STEP: begin
                w_en = 1'b1;
                if (pick_r) begin
                    w_data = r_rd_b;
                    n_idx  = right_w[AW-1:0];
                end else if (pick_l) begin
                    w_data = r_rd_a;
                    n_idx  = left_w[AW-1:0];
                end
            end
            OP_PLACE: begin
                w_en = 1'b1;
            end
            OP_OVF: begin
                n_ovf = 1'b1;
            end
            default: begin
                w_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        r_rd_a <= mem[addr_a];
        r_rd_b <= mem[addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= '0;
            r_count <= '0;
            r_prev  <= '0;
        end else begin
            r_size  <= n_size;
            r_count <= n_count;
            r_prev  <= n_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start  <= n_start;
        r_end    <= n_end;
        r_tag    <= n_tag;
        r_order  <= n_order;
        r_opened <= n_opened;
        r_ovf    <= n_ovf;
        r_res    <= n_res;
        r_cur    <= n_cur;
        r_idx    <= n_idx;
    end

    always_comb begin
        o_stat.reuse    = (r_size != '0) && (r_start > r_rd_a[EW-1:SW]);
        o_stat.full     = r_size == SW'(MAX_RESOURCES);
        o_stat.at_root  = r_idx == '0;
        o_stat.moved    = (i_uword.op == OP_UP_STEP) ? up_less : (pick_l || pick_r);
        o_stat.no_child = !has_left;
    end

    always_comb begin
        o_res.tag_out        = r_tag;
        o_res.resource       = RES_W'(r_res);
        o_res.opened_new     = r_opened;
        o_res.resource_count = RES_W'(r_count);
        o_res.overflow       = r_ovf;
        o_res.order_error    = r_order;
    end

    `IRAC_ASSERT_NOW(a_size_bound, i_clk, i_rst_n, 1'b1, r_size <= SW'(MAX_RESOURCES))
    `IRAC_ASSERT_NOW(a_count_size, i_clk, i_rst_n, 1'b1, r_count == r_size)
    `IRAC_ASSERT_NEXT(a_ins_grow, i_clk, i_rst_n, i_uword.op == OP_INS, r_size == $past(r_size) + SW'(1))

endmodule

// File: design/interval_resource_allocator_core.sv
// Top level of the interval resource allocator: sequencer, heap datapath, result register.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+---------------
//  in      | input     | i_in_valid / o_in_stall   | i_in  (t_in)
//  out     | output    | o_out_valid / i_out_stall | o_out (t_out)
//
// One item at a time: a new item is taken in only in the wait step. An overflow
// sets its flag and goes to the emit step, a reuse re-sets the root and sifts it
// down the heap, and an insert adds a new resource at the heap's end and sifts it up.
// Each heap level costs one registered read of the heap memory and one compare/write.
// Reset is synchronous, active low; it empties the heap and clears the counters.
// A result waits in the output register while the next item is taken in; the
// sequencer holds in its last step while the output stays stalled.
`include "interval_resource_allocator_core_defines.svh"
module interval_resource_allocator_core
    import irac_pkg::*;
#(
    parameter int MAX_RESOURCES = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    t_uword  uword;
    t_dpstat stat;
    t_out    res;
    logic    in_acc;
    logic    out_free;
    logic    emit;
    logic    r_out_valid;
    logic    n_out_valid;
    t_out    r_out;

    assign o_in_stall = uword.op != OP_LOAD;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign emit       = (uword.op == OP_EMIT) && out_free;

    irac_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_uword    (uword)
    );

    irac_dp #(
        .MAX_RESOURCES (MAX_RESOURCES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_uword  (uword),
        .i_in_acc (in_acc),
        .i_in     (i_in),
        .o_stat   (stat),
        .o_res    (res)
    );

    always_comb begin
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `IRAC_ASSERT_NEXT(a_busy_after_acc, i_clk, i_rst_n, in_acc, o_in_stall)
    `IRAC_ASSERT_NOW(a_ovf_no_res, i_clk, i_rst_n, o_out_valid && o_out.overflow, o_out.resource == '0 && !o_out.opened_new)

endmodule
